// ===== rtl/ttcs_pkg.sv =====
// shared types, constants and helpers for the triangle transform, cull and shade pipeline
package ttcs_pkg;

  localparam int FRAC      = 16;
  localparam int CW        = 32;
  localparam int ROT_W     = 18;
  localparam int SCALE_W   = 21;
  localparam int HALF_W    = 13;
  localparam int CFG_W     = 21;
  localparam int CFG_IDX_W = 3;
  localparam int PIX_W     = 16;
  localparam int SHADE_W   = 4;
  localparam int NRM_W     = 24;
  localparam int DIV_N_W   = 52;
  localparam int DIV_D_W   = 32;
  localparam int ONE_FX    = 1 << FRAC;

  localparam logic [CFG_IDX_W-1:0] REG_COS_Z   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_Z   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_W  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_H  = 3'd7;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [PIX_W-1:0] pix_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef vec_t [2:0] tri_t;

  typedef struct packed {
    logic               visible;
    logic [SHADE_W-1:0] shade;
  } face_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] cos_z;
    logic signed [ROT_W-1:0] sin_z;
    logic signed [ROT_W-1:0] cos_x;
    logic signed [ROT_W-1:0] sin_x;
  } rot_t;

  typedef struct packed {
    logic [SCALE_W-1:0] x_scale;
    logic [SCALE_W-1:0] y_scale;
    logic [HALF_W-1:0]  half_w;
    logic [HALF_W-1:0]  half_h;
  } view_t;

  function automatic coord_t sat32(input logic signed [63:0] v);
    coord_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ttcs_xform.sv =====
// rotation about z then x and shift along z, four register stages
module ttcs_xform (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ttcs_pkg::tri_t  in_tri,
  input  ttcs_pkg::rot_t  rot,
  output logic            out_valid,
  output ttcs_pkg::tri_t  out_tri
);
  import ttcs_pkg::*;

  logic [3:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  assign out_valid = vld[3];

  for (genvar v = 0; v < 3; v++) begin : g_vtx
    logic signed [49:0] p_xc, p_ys, p_xs, p_yc;
    coord_t             z_s1;
    logic signed [50:0] d_x, d_y;
    coord_t             x_s2, y_s2, z_s2;
    logic signed [49:0] q_yc, q_zs, q_ys, q_zc;
    coord_t             x_s3;
    logic signed [50:0] d_y2, d_z2;
    coord_t             z_rot;
    coord_t             x_s4, y_s4, z_s4;

    assign d_x   = 51'(p_xc) - 51'(p_ys);
    assign d_y   = 51'(p_xs) + 51'(p_yc);
    assign d_y2  = 51'(q_yc) - 51'(q_zs);
    assign d_z2  = 51'(q_ys) + 51'(q_zc);
    assign z_rot = sat32(64'(d_z2 >>> FRAC));

    always_ff @(posedge clk) begin
      if (en) begin
        p_xc <= $signed(in_tri[v].x) * $signed(rot.cos_z);
        p_ys <= $signed(in_tri[v].y) * $signed(rot.sin_z);
        p_xs <= $signed(in_tri[v].x) * $signed(rot.sin_z);
        p_yc <= $signed(in_tri[v].y) * $signed(rot.cos_z);
        z_s1 <= in_tri[v].z;
        x_s2 <= sat32(64'(d_x >>> FRAC));
        y_s2 <= sat32(64'(d_y >>> FRAC));
        z_s2 <= z_s1;
        q_yc <= y_s2 * $signed(rot.cos_x);
        q_zs <= z_s2 * $signed(rot.sin_x);
        q_ys <= y_s2 * $signed(rot.sin_x);
        q_zc <= z_s2 * $signed(rot.cos_x);
        x_s3 <= x_s2;
        x_s4 <= x_s3;
        y_s4 <= sat32(64'(d_y2 >>> FRAC));
        z_s4 <= sat32(64'(z_rot) + (64'sd3 <<< FRAC));
      end
    end

    assign out_tri[v].x = x_s4;
    assign out_tri[v].y = y_s4;
    assign out_tri[v].z = z_s4;
  end

endmodule

// ===== rtl/ttcs_cull.sv =====
// face normal, back-face test and flat shade level, nine register stages
module ttcs_cull (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ttcs_pkg::tri_t  in_tri,
  output logic            out_valid,
  output ttcs_pkg::tri_t  out_tri,
  output ttcs_pkg::face_t out_face
);
  import ttcs_pkg::*;

  localparam int STAGES = 9;

  function automatic coord_t comp(input vec_t p, input logic [1:0] j);
    coord_t r;
    case (j)
      2'd0:    r = p.x;
      2'd1:    r = p.y;
      default: r = p.z;
    endcase
    return r;
  endfunction

  logic [STAGES-1:0] vld;
  tri_t              tri_p [STAGES];

  logic signed [32:0]       e   [6];
  logic signed [32:0]       sh1 [6];
  logic signed [32:0]       sh2 [6];
  logic signed [30:0]       es_c [6];
  logic                     fit31, fit32;
  logic signed [30:0]       es  [6];
  logic signed [61:0]       m   [6];
  logic signed [62:0]       n2  [3];
  logic signed [62:0]       n3  [3];
  logic [62:0]              mask;
  logic [5:0]               t_c, t3;
  logic signed [NRM_W-1:0]  ns  [3];
  logic signed [55:0]       dp  [3];
  logic signed [47:0]       sq  [3];
  logic                     nz5;
  logic signed [57:0]       dot;
  logic                     vis6, nz6;
  logic [48:0]              len2;
  logic [53:0]              lim;
  logic [13:1]              le7;
  logic                     vis7, nz7;
  logic [SHADE_W-1:0]       kc, shade_c;
  face_t                    face8;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tri_p[0] <= in_tri;
      for (int i = 1; i < STAGES; i++) begin
        tri_p[i] <= tri_p[i-1];
      end
    end
  end

  // edges and the shared pre-shift that keeps them inside 31 bits
  always_comb begin
    fit31 = 1'b1;
    fit32 = 1'b1;
    for (int j = 0; j < 3; j++) begin
      e[j]   = 33'(comp(in_tri[1], 2'(j))) - 33'(comp(in_tri[0], 2'(j)));
      e[3+j] = 33'(comp(in_tri[2], 2'(j))) - 33'(comp(in_tri[0], 2'(j)));
    end
    for (int j = 0; j < 6; j++) begin
      if (!(e[j][32:30] == 3'b000 || e[j][32:30] == 3'b111)) fit31 = 1'b0;
      if (e[j][32] != e[j][31]) fit32 = 1'b0;
      sh1[j] = e[j] >>> 1;
      sh2[j] = e[j] >>> 2;
    end
    // the shift is chosen over both edges and all their components together
    for (int j = 0; j < 6; j++) begin
      es_c[j] = fit31 ? e[j][30:0] : (fit32 ? sh1[j][30:0] : sh2[j][30:0]);
    end
  end

  // leading sign search over the three normal components
  always_comb begin
    mask = '0;
    for (int j = 0; j < 3; j++) begin
      mask = mask | (n2[j] ^ {63{n2[j][62]}});
    end
    t_c = '0;
    for (int i = NRM_W - 1; i < 62; i++) begin
      if (mask[i]) t_c = 6'(i - (NRM_W - 2));
    end
  end

  assign dot = 58'(dp[0]) + 58'(dp[1]) + 58'(dp[2]);

  always_comb begin
    kc = '0;
    for (int kk = 1; kk <= 13; kk++) begin
      if (le7[kk]) kc = SHADE_W'(kk);
    end
    shade_c = (vis7 && nz7 && kc != 4'd13) ? kc : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        es[j] <= es_c[j];
      end
      m[0] <= es[1] * es[5];
      m[1] <= es[2] * es[4];
      m[2] <= es[2] * es[3];
      m[3] <= es[0] * es[5];
      m[4] <= es[0] * es[4];
      m[5] <= es[1] * es[3];
      n2[0] <= 63'(m[0]) - 63'(m[1]);
      n2[1] <= 63'(m[2]) - 63'(m[3]);
      n2[2] <= 63'(m[4]) - 63'(m[5]);
      for (int j = 0; j < 3; j++) begin
        n3[j] <= n2[j];
        ns[j] <= NRM_W'(n3[j] >>> t3);
        dp[j] <= ns[j] * $signed(comp(tri_p[4][0], 2'(j)));
        sq[j] <= ns[j] * ns[j];
      end
      t3   <= t_c;
      nz5  <= ns[2][NRM_W-1];
      vis6 <= dot[57];
      nz6  <= nz5;
      len2 <= 49'(sq[0][46:0]) + 49'(sq[1][46:0]) + 49'(sq[2][46:0]);
      lim  <= 54'(sq[2][46:0]) * 54'd169;
      for (int kk = 1; kk <= 13; kk++) begin
        le7[kk] <= (55'(len2) * 55'(kk * kk)) <= 55'(lim);
      end
      vis7  <= vis6;
      nz7   <= nz6;
      face8 <= '{visible: vis7, shade: shade_c};
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_tri   = tri_p[STAGES-1];
  assign out_face  = face8;

endmodule

// ===== rtl/ttcs_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module ttcs_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [ttcs_pkg::DIV_N_W-1:0]   num,
  input  logic [ttcs_pkg::DIV_D_W-1:0]   den,
  input  logic                           neg,
  output logic [ttcs_pkg::DIV_N_W-1:0]   quo,
  output logic                           quo_neg
);
  import ttcs_pkg::*;

  localparam int N = DIV_N_W;
  localparam int D = DIV_D_W;

  logic [N-1:0] nq  [N];
  logic [D-1:0] rem [N];
  logic [D-1:0] dv  [N];
  logic         sg  [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [N-1:0] nq_in;
    logic [D-1:0] rem_in, dv_in;
    logic         sg_in;
    logic [D:0]   trial, diff;
    logic         ge;

    if (i == 0) begin : g_first
      assign nq_in  = num;
      assign rem_in = '0;
      assign dv_in  = den;
      assign sg_in  = neg;
    end else begin : g_next
      assign nq_in  = nq[i-1];
      assign rem_in = rem[i-1];
      assign dv_in  = dv[i-1];
      assign sg_in  = sg[i-1];
    end

    // remainder shifts in the next numerator bit while the quotient bit shifts in below
    assign trial = {rem_in, nq_in[N-1]};
    assign diff  = trial - {1'b0, dv_in};
    assign ge    = trial >= {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? diff[D-1:0] : trial[D-1:0];
        nq[i]  <= {nq_in[N-2:0], ge};
        dv[i]  <= dv_in;
        sg[i]  <= sg_in;
      end
    end
  end

  assign quo     = nq[N-1];
  assign quo_neg = sg[N-1];

endmodule

// ===== rtl/ttcs_proj.sv =====
// perspective divide, viewport scale and pixel saturation for the six screen coordinates
module ttcs_proj (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  ttcs_pkg::tri_t         in_tri,
  input  ttcs_pkg::face_t        in_face,
  input  ttcs_pkg::view_t        view,
  output logic                   out_valid,
  output ttcs_pkg::face_t        out_face,
  output ttcs_pkg::pix_t [5:0]   out_pix
);
  import ttcs_pkg::*;

  localparam int STAGES = DIV_N_W + 5;

  logic [STAGES-1:0] vld;
  face_t             face_d [STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      face_d[0] <= in_face;
      for (int i = 1; i < STAGES; i++) begin
        face_d[i] <= face_d[i-1];
      end
    end
  end

  for (genvar c = 0; c < 6; c++) begin : g_coord
    coord_t               crd, zc;
    logic [SCALE_W-1:0]   scale;
    logic [HALF_W-1:0]    half;
    logic signed [53:0]   num1;
    coord_t               z1;
    logic [53:0]          mag_c;
    logic [DIV_N_W-1:0]   nmag2;
    logic [DIV_D_W-1:0]   den2;
    logic                 neg2;
    logic [DIV_N_W-1:0]   qmag;
    logic                 qneg;
    logic signed [53:0]   qs;
    logic signed [41:0]   q3;
    logic signed [56:0]   v4;
    logic signed [56:0]   vr;
    logic signed [40:0]   vt;
    pix_t                 px5;

    if (c % 2 == 0) begin : g_x
      assign crd   = in_tri[c/2].x;
      assign scale = view.x_scale;
      assign half  = view.half_w;
    end else begin : g_y
      assign crd   = in_tri[c/2].y;
      assign scale = view.y_scale;
      assign half  = view.half_h;
    end
    assign zc = in_tri[c/2].z;

    assign mag_c = num1[53] ? 54'(-num1) : 54'(num1);

    // a zero depth divides by one in fixed point; rounding up the magnitude gives a floor
    always_ff @(posedge clk) begin
      if (en) begin
        num1 <= crd * $signed({1'b0, scale});
        z1   <= zc;
        if (z1 == '0) begin
          nmag2 <= num1[53] ? mag_c[DIV_N_W-1:0] + DIV_N_W'(ONE_FX - 1) : mag_c[DIV_N_W-1:0];
          den2  <= DIV_D_W'(ONE_FX);
          neg2  <= num1[53];
        end else begin
          nmag2 <= mag_c[DIV_N_W-1:0];
          den2  <= z1[CW-1] ? DIV_D_W'(-z1) : DIV_D_W'(z1);
          neg2  <= num1[53] ^ z1[CW-1];
        end
      end
    end

    ttcs_div u_div (
      .clk     (clk),
      .en      (en),
      .num     (nmag2),
      .den     (den2),
      .neg     (neg2),
      .quo     (qmag),
      .quo_neg (qneg)
    );

    assign qs = qneg ? -54'(qmag) : 54'(qmag);
    assign vr = v4[56] ? (v4 + 57'(ONE_FX - 1)) >>> FRAC : v4 >>> FRAC;
    assign vt = vr[40:0];

    always_ff @(posedge clk) begin
      if (en) begin
        if (qs > 54'sd1099511627776) begin
          q3 <= 42'sd1099511627776;
        end else if (qs < -54'sd1099511627776) begin
          q3 <= -42'sd1099511627776;
        end else begin
          q3 <= qs[41:0];
        end
        v4 <= (43'(q3) + 43'(ONE_FX)) * $signed({1'b0, half});
        if (!face_d[STAGES-2].visible) begin
          px5 <= '0;
        end else if (vt > 41'sd32767) begin
          px5 <= 16'sh7FFF;
        end else if (vt < -41'sd32768) begin
          px5 <= 16'sh8000;
        end else begin
          px5 <= vt[PIX_W-1:0];
        end
      end
    end

    assign out_pix[c] = px5;
  end

  assign out_valid = vld[STAGES-1];
  assign out_face  = face_d[STAGES-1];

endmodule

// ===== rtl/triangle_transform_cull_shade.sv =====
// an accepted word passes the rotate, cull and project sections in turn to its result word
// throughput: one triangle per cycle unless held; 52-stage divider chains set depth, not rate
// the whole pipeline advances together and holds while the output word is not taken
// reset clears the valid bits and loads the rotation, projection and screen registers
// with identity rotation, scales 0.9375 and 1.0, and a half screen of 128 by 120
module triangle_transform_cull_shade (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x .. vertex_c_z, 32 bits each
  input  logic [287:0]                     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // shade_level[3:0], screen_a_x, screen_a_y, screen_b_x, screen_b_y,
  // screen_c_x, screen_c_y (16 bits each), zero pad [103:100]
  output logic [103:0]                     m_axis_tdata,
  // visible
  output logic                             m_axis_tuser,
  input  logic                             cfg_wen,
  input  logic [ttcs_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ttcs_pkg::CFG_W-1:0]       cfg_wdata
);
  import ttcs_pkg::*;

  rot_t   rot;
  view_t  view;
  logic   en;
  tri_t   in_tri;
  logic   xf_valid, cl_valid;
  tri_t   xf_tri, cl_tri;
  face_t  cl_face, out_face;
  pix_t [5:0] pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot.cos_z    <= ROT_W'(ONE_FX);
      rot.sin_z    <= '0;
      rot.cos_x    <= ROT_W'(ONE_FX);
      rot.sin_x    <= '0;
      view.x_scale <= SCALE_W'(15 << (FRAC - 4));
      view.y_scale <= SCALE_W'(ONE_FX);
      view.half_w  <= HALF_W'(128);
      view.half_h  <= HALF_W'(120);
    end else if (cfg_wen) begin
      case (cfg_idx)
        REG_COS_Z:   rot.cos_z    <= cfg_wdata[ROT_W-1:0];
        REG_SIN_Z:   rot.sin_z    <= cfg_wdata[ROT_W-1:0];
        REG_COS_X:   rot.cos_x    <= cfg_wdata[ROT_W-1:0];
        REG_SIN_X:   rot.sin_x    <= cfg_wdata[ROT_W-1:0];
        REG_X_SCALE: view.x_scale <= cfg_wdata[SCALE_W-1:0];
        REG_Y_SCALE: view.y_scale <= cfg_wdata[SCALE_W-1:0];
        REG_HALF_W:  view.half_w  <= cfg_wdata[HALF_W-1:0];
        REG_HALF_H:  view.half_h  <= cfg_wdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the output register is empty or being taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  for (genvar v = 0; v < 3; v++) begin : g_unpack
    assign in_tri[v].x = s_axis_tdata[v*96 +: 32];
    assign in_tri[v].y = s_axis_tdata[v*96 + 32 +: 32];
    assign in_tri[v].z = s_axis_tdata[v*96 + 64 +: 32];
  end

  ttcs_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .in_tri    (in_tri),
    .rot       (rot),
    .out_valid (xf_valid),
    .out_tri   (xf_tri)
  );

  ttcs_cull u_cull (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (xf_valid),
    .in_tri    (xf_tri),
    .out_valid (cl_valid),
    .out_tri   (cl_tri),
    .out_face  (cl_face)
  );

  ttcs_proj u_proj (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cl_valid),
    .in_tri    (cl_tri),
    .in_face   (cl_face),
    .view      (view),
    .out_valid (m_axis_tvalid),
    .out_face  (out_face),
    .out_pix   (pix)
  );

  assign m_axis_tdata = {4'b0000, pix[5], pix[4], pix[3], pix[2], pix[1], pix[0],
                         out_face.shade};
  assign m_axis_tuser = out_face.visible;

`ifndef SYNTHESIS
  a_culled_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("culled triangle word carries nonzero data");

  a_shade_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd12)
    else $error("shade level above twelve");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output word valid straight after reset");
`endif

endmodule

// ===== test/ttcs_checker.sv =====
// checker for the triangle transform, cull and shade pipeline: mirrors registers, predicts, compares
module ttcs_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [287:0]                   s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [103:0]                   m_axis_tdata,
  input  logic                           m_axis_tuser,
  input  logic                           cfg_wen,
  input  logic [ttcs_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ttcs_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             fail_count,
  output int                             faces_pending,
  output int                             faces_checked,
  output int                             faces_shown
);
  import ttcs_pkg::*;

  typedef struct packed {
    logic               visible;
    logic [SHADE_W-1:0] shade;
    pix_t [5:0]         pix;
  } face_word_t;

  face_word_t faces_due[$];
  rot_t       rot;
  view_t      view;

  function automatic longint fshr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sat_c(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint to_pixel(longint c, longint zc, longint scale, longint half);
    longint num, q, v;
    num = c * scale;
    q = (zc != 0) ? num / zc : fshr(num, FRAC);
    q = clip(q, -(64'sd1 << 40), 64'sd1 << 40);
    v = (q + ONE_FX) * half;
    v = v / ONE_FX;
    return clip(v, -32768, 32767);
  endfunction

  function automatic face_word_t shade_face(logic [287:0] d);
    face_word_t r;
    longint pt[3][3];
    longint e[6];
    longint n[3];
    longint cz, sz, cx, sx, x, y, z, x1, y1, y2, z2, dot, len2, lim, k;
    int s, t;
    bit fits;
    cz = rot.cos_z; sz = rot.sin_z; cx = rot.cos_x; sx = rot.sin_x;
    r = '0;
    for (int v = 0; v < 3; v++) begin
      x = coord_t'(d[96*v +: 32]);
      y = coord_t'(d[96*v+32 +: 32]);
      z = coord_t'(d[96*v+64 +: 32]);
      x1 = sat_c(fshr(x * cz - y * sz, FRAC));
      y1 = sat_c(fshr(x * sz + y * cz, FRAC));
      y2 = sat_c(fshr(y1 * cx - z * sx, FRAC));
      z2 = sat_c(fshr(y1 * sx + z * cx, FRAC));
      pt[v][0] = x1;
      pt[v][1] = y2;
      pt[v][2] = sat_c(z2 + (64'sd3 << FRAC));
    end
    for (int j = 0; j < 3; j++) begin
      e[j] = pt[1][j] - pt[0][j];
      e[3+j] = pt[2][j] - pt[0][j];
    end
    for (s = 0; s < 2; s++) begin
      fits = 1;
      foreach (e[j]) if (fshr(e[j], s) < -(64'sd1 << 30) || fshr(e[j], s) >= (64'sd1 << 30))
        fits = 0;
      if (fits) break;
    end
    foreach (e[j]) e[j] = fshr(e[j], s);
    n[0] = e[1] * e[5] - e[2] * e[4];
    n[1] = e[2] * e[3] - e[0] * e[5];
    n[2] = e[0] * e[4] - e[1] * e[3];
    for (t = 0; t < 62; t++) begin
      fits = 1;
      foreach (n[j]) if (fshr(n[j], t) < -(64'sd1 << 23) || fshr(n[j], t) >= (64'sd1 << 23))
        fits = 0;
      if (fits) break;
    end
    foreach (n[j]) n[j] = fshr(n[j], t);
    dot = n[0] * pt[0][0] + n[1] * pt[0][1] + n[2] * pt[0][2];
    if (dot >= 0) return r;
    r.visible = 1;
    if (n[2] < 0) begin
      len2 = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
      lim = 169 * n[2] * n[2];
      k = 13;
      while (k > 0 && k * k * len2 > lim) k--;
      r.shade = SHADE_W'((k >= 13) ? 0 : k);
    end
    for (int v = 0; v < 3; v++) begin
      r.pix[2*v]   = PIX_W'(to_pixel(pt[v][0], pt[v][2], view.x_scale, view.half_w));
      r.pix[2*v+1] = PIX_W'(to_pixel(pt[v][1], pt[v][2], view.y_scale, view.half_h));
    end
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch on face %0d: %s got %0d want %0d", faces_checked, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    face_word_t want;
    pix_t p;
    if (rst) begin
      rot  <= '{cos_z: ONE_FX, sin_z: 0, cos_x: ONE_FX, sin_x: 0};
      view <= '{x_scale: 61440, y_scale: ONE_FX, half_w: 128, half_h: 120};
      faces_due.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        faces_due.push_back(shade_face(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (faces_due.size() == 0) begin
          report("unexpected result word, words due", 1, 0);
        end else begin
          want = faces_due.pop_front();
          if (m_axis_tuser !== want.visible) report("visible", m_axis_tuser, want.visible);
          if (m_axis_tdata[3:0] !== want.shade) report("shade", m_axis_tdata[3:0], want.shade);
          for (int i = 0; i < 6; i++) begin
            p = m_axis_tdata[4+16*i +: 16];
            if (p !== want.pix[i]) report($sformatf("pixel %0d", i), p, want.pix[i]);
          end
          if (m_axis_tdata[103:100] !== 4'd0) report("pad", m_axis_tdata[103:100], 0);
          faces_checked++;
          if (want.visible) faces_shown++;
        end
      end
      if (cfg_wen) begin
        case (cfg_idx)
          REG_COS_Z:   rot.cos_z    <= cfg_wdata[ROT_W-1:0];
          REG_SIN_Z:   rot.sin_z    <= cfg_wdata[ROT_W-1:0];
          REG_COS_X:   rot.cos_x    <= cfg_wdata[ROT_W-1:0];
          REG_SIN_X:   rot.sin_x    <= cfg_wdata[ROT_W-1:0];
          REG_X_SCALE: view.x_scale <= cfg_wdata[SCALE_W-1:0];
          REG_Y_SCALE: view.y_scale <= cfg_wdata[SCALE_W-1:0];
          REG_HALF_W:  view.half_w  <= cfg_wdata[HALF_W-1:0];
          REG_HALF_H:  view.half_h  <= cfg_wdata[HALF_W-1:0];
          default: ;
        endcase
      end
    end
    faces_pending = faces_due.size();
  end

  initial begin
    fail_count = 0;
    faces_pending = 0;
    faces_checked = 0;
    faces_shown = 0;
  end
endmodule

// ===== test/triangle_transform_cull_shade_tb.sv =====
// testbench top: triangle stimulus, register phases, stalls and the verdict
module triangle_transform_cull_shade_tb;
  import ttcs_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN = 80;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [287:0]         s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [103:0]         m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  int  fail_count, faces_pending, faces_checked, faces_shown;
  int  cycles;
  int  phases;
  bit  busy_sender;
  bit  long_hold;

  triangle_transform_cull_shade u_dut (.*);

  ttcs_checker u_check (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int pick_gap(bit busy);
    int r;
    r = $urandom_range(0, 99);
    if (busy || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
      m_axis_tready <= 1;
      @(posedge clk);
      if (pick_gap(busy_sender) > 0) begin
        m_axis_tready <= 0;
        repeat (pick_gap(0) + 1) @(posedge clk);
      end
    end
  end

  task automatic send_face(logic [287:0] d);
    int g;
    s_axis_tvalid <= 1;
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
    g = pick_gap(busy_sender);
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic set_view(logic [CFG_W-1:0] v[8]);
    logic [CFG_IDX_W-1:0] idx[8];
    idx = '{REG_COS_Z, REG_SIN_Z, REG_COS_X, REG_SIN_X,
            REG_X_SCALE, REG_Y_SCALE, REG_HALF_W, REG_HALF_H};
    s_axis_tvalid <= 0;
    wait (faces_pending == 0);
    repeat (DRAIN) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_wen   <= 1;
      cfg_idx   <= idx[i];
      cfg_wdata <= v[i];
      @(posedge clk);
    end
    cfg_wen <= 0;
    @(posedge clk);
    phases++;
  endtask

  function automatic logic [CFG_W-1:0] rot_val();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -65536;
    if (r == 1) return 65536;
    if (r == 2) return $urandom;
    return $urandom_range(0, 131072) - 65536;
  endfunction

  function automatic logic [31:0] near_coord();
    return $urandom_range(0, 393216) - 196608;
  endfunction

  // mostly small sane triangles, some full-range noise
  function automatic logic [287:0] rand_face();
    logic [287:0] d;
    int r;
    r = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++)
      d[32*i +: 32] = (r < 7) ? near_coord() : (r < 9 ? $urandom : $urandom >>> 8);
    if (r == 6) d[64 +: 32] = -(3 << FRAC);
    return d;
  endfunction

  function automatic logic [287:0] face_of(int ax, int ay, int az, int bx, int by, int bz,
                                           int cx, int cy, int cz);
    return {cz, cy, cx, bz, by, bx, az, ay, ax};
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) send_face(rand_face());
  endtask

  logic [CFG_W-1:0] v[8];
  localparam int U = ONE_FX;

  initial begin
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_wen = 0;
    cfg_idx = '0;
    cfg_wdata = '0;
    cycles = 0;
    phases = 0;
    busy_sender = 0;
    long_hold = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed faces at reset settings
    send_face('0);
    send_face(face_of(0, 0, 0, U, 0, 0, 0, U, 0));
    send_face(face_of(0, 0, 0, 0, U, 0, U, 0, 0));
    send_face(face_of(-U, -U, U, U, -U, 0, 0, U, -U));
    send_face(face_of(0, U, -U, U, -U, 0, -U, -U, U));
    send_face(face_of(U, 0, -3*U, 0, U, -3*U, -U, -U, -3*U));
    send_face(face_of(U, 0, -3*U, -U, -U, 0, 0, U, U));
    send_face(face_of(0, 0, -3*U, 0, U, 0, U, 0, 0));
    send_face({9{32'h7FFFFFFF}});
    send_face({9{32'h80000000}});
    send_face(face_of(32'h7FFFFFFF, 32'h80000000, 0, 32'h80000000, 0, 32'h7FFFFFFF,
                      0, 32'h7FFFFFFF, 32'h80000000));
    send_face(face_of(32'h80000000, 0, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 0,
                      32'h7FFFFFFF, 32'h80000000, 32'h80000000));
    send_face(face_of(0, 0, 100*U, 1, 0, 100*U, 0, 1, 100*U));
    send_face(face_of(0, 0, 100*U, 0, 1, 100*U, 1, 0, 100*U));
    send_face(face_of(-U, 0, -2*U, U, 0, -2*U, 0, 0, -U));
    send_face(face_of(0, 0, -U, U, 0, -2*U, -U, 0, -2*U));
    send_face(face_of(1, 2, 3, 1, 2, 3, 4, 5, 6));
    send_face({9{32'hFFFFFFFF}});
    send_face({9{32'h00000001}});
    random_run(300);

    // long receiver hold while the sender keeps offering
    busy_sender = 1;
    long_hold = 1;
    random_run(200);
    busy_sender = 0;

    v = '{rot_val(), rot_val(), rot_val(), rot_val(), $urandom_range(0, 1 << 20),
          $urandom_range(0, 1 << 20), $urandom_range(1, 4096), $urandom_range(1, 4096)};
    set_view(v);
    random_run(250);

    v = '{-65536, 65536, -65536, 65536, 0, 0, 1, 1};
    set_view(v);
    random_run(200);

    v = '{65536, -65536, 0, -65536, 1 << 20, 1 << 20, 4096, 4096};
    set_view(v);
    random_run(250);

    // raw bit patterns beyond the stated ranges
    v = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    set_view(v);
    random_run(200);

    v = '{46341, 46341, 56756, -32768, 61440, 65536, 320, 240};
    set_view(v);
    busy_sender = 1;
    random_run(150);
    busy_sender = 0;
    random_run(200);

    s_axis_tvalid <= 0;
    wait (faces_pending == 0);
    repeat (DRAIN) @(posedge clk);
    $display("checked %0d triangles, %0d drawn and %0d culled", faces_checked, faces_shown,
             faces_checked - faces_shown);
    $display("register settings used: %0d besides reset", phases);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/ttcs_pkg.sv
rtl/ttcs_xform.sv
rtl/ttcs_cull.sv
rtl/ttcs_div.sv
rtl/ttcs_proj.sv
rtl/triangle_transform_cull_shade.sv
test/ttcs_checker.sv
test/triangle_transform_cull_shade_tb.sv
